[sv/cvt_pkg.sv]
// Shared types and constants for the constant verification table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package cvt_pkg;

   // Fixed payload widths
   localparam int OPCODE_W = 2;
   localparam int ADDR_W   = 64;
   localparam int SIZE_W   = 4;
   localparam int THREAD_W = 2;
   localparam int SHIFT_W  = 3;

   // Default table geometry
   localparam int CVT_ENTRIES    = 8;
   localparam int CVT_INDEX_BITS = 10;
   localparam int CVT_AGE_BITS   = 8;

   // Reset value of the pc shift register
   localparam logic [SHIFT_W-1:0] PC_SHIFT_RESET = 3'd2;

   // Request operations
   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_CHECK  = 2'd1,
      OP_STORE  = 2'd2,
      OP_INSERT = 2'd3
   } opcode_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic evaluate;  // register the per-entry match results
      logic commit;    // update the table and load the response register
   } cvt_cmd_type;

endpackage

[sv/cvt_if.sv]
// Valid/ready channel interfaces for requests, responses and the csr write port.
// Depends on cvt_pkg for the payload widths.
interface cvt_req_if;
   import cvt_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ADDR_W-1:0]   pc;
   logic [ADDR_W-1:0]   data_address;
   logic [SIZE_W-1:0]   access_size;
   logic [THREAD_W-1:0] thread;

   modport source (output valid, opcode, pc, data_address, access_size, thread,
                   input ready);
   modport sink   (input valid, opcode, pc, data_address, access_size, thread,
                   output ready);
endinterface

interface cvt_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic cleared_any;

   modport source (output valid, hit, cleared_any, input ready);
   modport sink   (input valid, hit, cleared_any, output ready);
endinterface

interface cvt_csr_if;
   import cvt_pkg::*;
   logic               valid;
   logic               ready;
   logic [SHIFT_W-1:0] pc_shift;

   modport source (output valid, pc_shift, input ready);
   modport sink   (input valid, pc_shift, output ready);
endinterface

[sv/cvt_ctrl.sv]
// Controller state machine: sequences capture, evaluate and commit for each request
// and owns the response valid flag. Depends on cvt_pkg.
module cvt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cvt_pkg::cvt_cmd_type cmd
);
   import cvt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EVAL   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit_ok;
   logic      accept;

   // Commit only when the response register is free or being drained
   assign commit_ok = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_COMMIT) && commit_ok);
   assign accept    = req_valid && req_ready;

   // Advance the state machine
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_ok) state_in = accept ? ST_EVAL : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Issue datapath commands
   always_comb begin
      cmd.capture  = accept;
      cmd.evaluate = (state_ff == ST_EVAL);
      cmd.commit   = (state_ff == ST_COMMIT) && commit_ok;
   end

   // Set on commit, drop once the response is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/cvt_dp.sv]
// Datapath: request register, entry table, per-entry comparators, victim selection,
// table update and response payload register. Depends on cvt_pkg.
module cvt_dp #(
   parameter int ENTRIES    = cvt_pkg::CVT_ENTRIES,
   parameter int INDEX_BITS = cvt_pkg::CVT_INDEX_BITS,
   parameter int AGE_BITS   = cvt_pkg::CVT_AGE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cvt_pkg::cvt_cmd_type          cmd,
   input  logic                          csr_write,
   input  logic [cvt_pkg::SHIFT_W-1:0]   csr_pc_shift,
   input  logic [cvt_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [cvt_pkg::ADDR_W-1:0]    req_pc,
   input  logic [cvt_pkg::ADDR_W-1:0]    req_data_address,
   input  logic [cvt_pkg::SIZE_W-1:0]    req_access_size,
   input  logic [cvt_pkg::THREAD_W-1:0]  req_thread,
   output logic                          rsp_hit,
   output logic                          rsp_cleared_any
);
   import cvt_pkg::*;

   localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};
   localparam logic [ADDR_W-1:0]   ADDR_ONE = {{(ADDR_W-1){1'b0}}, 1'b1};

   // Configuration
   logic [SHIFT_W-1:0]    pc_shift_ff;

   // Captured request
   logic [OPCODE_W-1:0]   req_op_ff;
   logic [ADDR_W-1:0]     req_pc_ff;
   logic [ADDR_W-1:0]     req_addr_ff;
   logic [SIZE_W-1:0]     req_size_ff;
   logic [THREAD_W-1:0]   req_thr_ff;
   opcode_type            op;

   // Entry table
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [INDEX_BITS-1:0] idx_ff  [ENTRIES];
   logic [ADDR_W-1:0]     addr_ff [ENTRIES];
   logic [SIZE_W-1:0]     size_ff [ENTRIES];
   logic [THREAD_W-1:0]   thr_ff  [ENTRIES];
   logic [AGE_BITS-1:0]   age_ff  [ENTRIES];
   logic [AGE_BITS-1:0]   age_in  [ENTRIES];

   // Evaluate stage
   logic [ADDR_W-1:0]     pc_shifted;
   logic [INDEX_BITS-1:0] lidx;
   logic [ADDR_W-1:0]     store_end;
   logic [ADDR_W-1:0]     load_end [ENTRIES];
   logic [ENTRIES-1:0]    match_full, match_it, overlap, victim, free, free_oh, hit_oh;
   logic [ENTRIES-1:0]    ins_oh;

   logic [INDEX_BITS-1:0] lidx_ff;
   logic [ENTRIES-1:0]    hit_oh_ff, match_it_ff, overlap_ff, ins_oh_ff;
   logic                  ins_full_ff;

   // Response payload
   logic                  hit_ff, hit_in;
   logic                  cleared_ff, cleared_in;
   logic                  any_hit;

   assign op = opcode_type'(req_op_ff);

   // Hold the pc shift register
   always_ff @(posedge clock) begin
      if (reset) pc_shift_ff <= PC_SHIFT_RESET;
      else if (csr_write) pc_shift_ff <= csr_pc_shift;
   end

   // Latch the accepted request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_op_ff   <= req_opcode;
         req_pc_ff   <= req_pc;
         req_addr_ff <= req_data_address;
         req_size_ff <= req_access_size;
         req_thr_ff  <= req_thread;
      end
   end

   // Form the load index and the store end address
   assign pc_shifted = req_pc_ff >> pc_shift_ff;
   assign lidx       = pc_shifted[INDEX_BITS-1:0];
   assign store_end  = req_addr_ff + {{(ADDR_W-SIZE_W){1'b0}}, req_size_ff} - ADDR_ONE;

   // Compare every entry against the request in parallel
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         load_end[i]   = addr_ff[i] + {{(ADDR_W-SIZE_W){1'b0}}, size_ff[i]} - ADDR_ONE;
         match_it[i]   = valid_ff[i] && (idx_ff[i] == lidx) && (thr_ff[i] == req_thr_ff);
         match_full[i] = match_it[i] && (addr_ff[i] == req_addr_ff);
         overlap[i]    = valid_ff[i] &&
                         (((req_addr_ff >= addr_ff[i]) && (req_addr_ff <= load_end[i])) ||
                          ((addr_ff[i] >= req_addr_ff) && (addr_ff[i] <= store_end)));
      end
   end

   // Pick the oldest entry: strictly below every lower entry, not above any higher one
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim[i] = 1'b1;
         for (int j = 0; j < ENTRIES; j++) begin
            if ((j < i) && !(age_ff[i] < age_ff[j])) victim[i] = 1'b0;
            if ((j > i) && !(age_ff[i] <= age_ff[j])) victim[i] = 1'b0;
         end
      end
   end

   // Isolate the lowest free entry and the lowest full match
   assign free    = ~valid_ff;
   assign free_oh = free & (~free + {{(ENTRIES-1){1'b0}}, 1'b1});
   assign hit_oh  = match_full & (~match_full + {{(ENTRIES-1){1'b0}}, 1'b1});
   assign ins_oh  = (|free) ? free_oh : victim;

   // Register the evaluate results
   always_ff @(posedge clock) begin
      if (cmd.evaluate) begin
         lidx_ff     <= lidx;
         hit_oh_ff   <= hit_oh;
         match_it_ff <= match_it;
         overlap_ff  <= overlap;
         ins_oh_ff   <= ins_oh;
         ins_full_ff <= ~(|free);
      end
   end

   assign any_hit = |hit_oh_ff;

   // Compute the table update and the response
   always_comb begin
      valid_in   = valid_ff;
      hit_in     = 1'b0;
      cleared_in = 1'b0;
      for (int i = 0; i < ENTRIES; i++) age_in[i] = age_ff[i];
      unique case (op)
         OP_CLEAR: begin
            valid_in   = '0;
            cleared_in = |valid_ff;
         end
         OP_CHECK: begin
            if (any_hit) begin
               hit_in = 1'b1;
               for (int i = 0; i < ENTRIES; i++) begin
                  age_in[i] = (age_ff[i] >> 1) | (hit_oh_ff[i] ? AGE_TOP : '0);
               end
            end else begin
               cleared_in = |match_it_ff;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (match_it_ff[i]) begin
                     valid_in[i] = 1'b0;
                     age_in[i]   = '0;
                  end
               end
            end
         end
         OP_STORE: begin
            cleared_in = |overlap_ff;
            for (int i = 0; i < ENTRIES; i++) begin
               if (overlap_ff[i]) begin
                  valid_in[i] = 1'b0;
                  age_in[i]   = '0;
               end
            end
         end
         OP_INSERT: begin
            for (int i = 0; i < ENTRIES; i++) begin
               age_in[i] = age_ff[i] >> 1;
               if (ins_oh_ff[i]) begin
                  valid_in[i] = 1'b1;
                  age_in[i]   = ins_full_ff ? AGE_TOP : ((age_ff[i] >> 1) | AGE_TOP);
               end
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   // Apply valid bits and ages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) age_ff[i] <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         for (int i = 0; i < ENTRIES; i++) age_ff[i] <= age_in[i];
      end
   end

   // Write the inserted entry's fields
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.commit && (op == OP_INSERT) && ins_oh_ff[i]) begin
            idx_ff[i]  <= lidx_ff;
            addr_ff[i] <= req_addr_ff;
            size_ff[i] <= req_size_ff;
            thr_ff[i]  <= req_thr_ff;
         end
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff     <= hit_in;
         cleared_ff <= cleared_in;
      end
   end

   assign rsp_hit         = hit_ff;
   assign rsp_cleared_any = cleared_ff;

endmodule

[sv/constant_verification_table.sv]
// Top level of the constant verification table: joins the channels to the
// controller and the datapath. Depends on cvt_pkg, cvt_if, cvt_ctrl and cvt_dp.
//
// Usage:
//   req_chan carries one request: opcode (clear all, constant check, store
//   invalidate, insert), pc, data_address, access_size and thread.
//   rsp_chan returns exactly one response per request: hit and cleared_any.
//   csr_chan writes the pc shift used to form the load index; it is always
//   ready. The user must write it only while no request is in flight; the
//   block itself does not enforce this.
// Sequence: a request is captured, all entries are compared and the results
//   registered, then the table is updated and the response register loaded.
// Overlap: a new request is accepted during the table update of the last one.
// Reset: all entries invalid with zero age, pc shift set to 2, no response
//   pending.
// Stall: a response waits in the output register while rsp_chan is not
//   ready; the next request is still accepted and compared, and its table
//   update waits until the pending response is taken.
module constant_verification_table #(
   parameter int ENTRIES    = cvt_pkg::CVT_ENTRIES,
   parameter int INDEX_BITS = cvt_pkg::CVT_INDEX_BITS,
   parameter int AGE_BITS   = cvt_pkg::CVT_AGE_BITS
) (
   input logic        clock,
   input logic        reset,
   cvt_req_if.sink    req_chan,
   cvt_rsp_if.source  rsp_chan,
   cvt_csr_if.sink    csr_chan
);
   import cvt_pkg::*;

   cvt_cmd_type cmd;

   assign csr_chan.ready = 1'b1;

   cvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   cvt_dp #(
      .ENTRIES    (ENTRIES),
      .INDEX_BITS (INDEX_BITS),
      .AGE_BITS   (AGE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write        (csr_chan.valid),
      .csr_pc_shift     (csr_chan.pc_shift),
      .req_opcode       (req_chan.opcode),
      .req_pc           (req_chan.pc),
      .req_data_address (req_chan.data_address),
      .req_access_size  (req_chan.access_size),
      .req_thread       (req_chan.thread),
      .rsp_hit          (rsp_chan.hit),
      .rsp_cleared_any  (rsp_chan.cleared_any)
   );

`ifndef SYNTHESIS
   // An accepted request is compared in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> cmd.evaluate)
      else $error("accepted request not evaluated");

   // A commit always presents a response
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_chan.valid)
      else $error("commit without response");

   // Evaluate never overlaps a commit or a capture
   assert property (@(posedge clock) disable iff (reset)
      cmd.evaluate |-> (!cmd.commit && !cmd.capture))
      else $error("evaluate overlaps another command");

   // A hit never reports cleared entries
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.hit && rsp_chan.cleared_any))
      else $error("hit with cleared entries");
`endif

endmodule

[tb/sv/constant_verification_table_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the constant verification table.
// Depends on cvt_pkg, the channel interfaces in cvt_if and the table top level.
module constant_verification_table_test;
   import cvt_pkg::*;

   localparam int RESPONSE_LATENCY = 2;
   localparam int CYCLE_LIMIT      = 600000;
   localparam int POOL_DEPTH       = 12;
   localparam int SENDER           = 0;
   localparam int RECEIVER         = 1;
   localparam int PHASE_REQUESTS   = 235;

   typedef struct packed {
      logic                      valid;
      logic [CVT_INDEX_BITS-1:0] load_index;
      logic [ADDR_W-1:0]         address;
      logic [SIZE_W-1:0]         size;
      logic [THREAD_W-1:0]       thread;
      logic [CVT_AGE_BITS-1:0]   age;
   } table_entry_type;

   typedef struct packed {
      logic hit;
      logic cleared_any;
   } table_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cvt_req_if req_bus ();
   cvt_rsp_if rsp_bus ();
   cvt_csr_if csr_bus ();

   constant_verification_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow copy of the table and its shift register
   table_entry_type    entry_shadow [CVT_ENTRIES];
   logic [SHIFT_W-1:0] shadow_pc_shift;

   // Responses still owed by the block, oldest first
   table_response_type pending_responses [$];
   table_response_type oldest_response;

   int error_count     = 0;
   int cycle_count     = 0;
   int rsp_stall_left  = 0;
   int rsp_hold_cycles = 0;
   int burst_left [2]  = '{0, 0};
   bit burst_quiet [2] = '{1'b0, 1'b0};

   // Recently inserted loads, reused so that checks and stores find entries
   logic [ADDR_W-1:0]   pool_pc      [POOL_DEPTH];
   logic [ADDR_W-1:0]   pool_addr    [POOL_DEPTH];
   logic [SIZE_W-1:0]   pool_size    [POOL_DEPTH];
   logic [THREAD_W-1:0] pool_thread  [POOL_DEPTH];

   always #5 clock = ~clock;

   // Stop a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("constant_verification_table_test: FAIL");
         $finish;
      end
   end

   // Wait per request or response: each burst is zero waits one time in four, else random waits
   function automatic int draw_wait(input int side);
      if (burst_left[side] == 0) begin
         burst_left[side]  = $urandom_range(8, 40);
         burst_quiet[side] = ($urandom_range(0, 3) == 0);
      end
      burst_left[side]--;
      return burst_quiet[side] ? 0 : $urandom_range(0, 16);
   endfunction

   // Shift every age right, mark the touched entry most recent
   function automatic void age_touch(input int slot);
      for (int i = 0; i < CVT_ENTRIES; i++) begin
         entry_shadow[i].age = entry_shadow[i].age >> 1;
         if (i == slot) entry_shadow[i].age[CVT_AGE_BITS-1] = 1'b1;
      end
   endfunction

   // Apply one request to the shadow table and return its response
   function automatic table_response_type predict_response(
      input opcode_type          op,
      input logic [ADDR_W-1:0]   pc,
      input logic [ADDR_W-1:0]   addr,
      input logic [SIZE_W-1:0]   size,
      input logic [THREAD_W-1:0] thr
   );
      table_response_type        resp;
      logic [CVT_INDEX_BITS-1:0] lidx;
      logic [ADDR_W-1:0]         store_end;
      logic [ADDR_W-1:0]         load_end;
      logic [ADDR_W-1:0]         base;
      logic [CVT_AGE_BITS-1:0]   best_age;
      int                        slot;
      bit                        found;
      resp      = '0;
      lidx      = CVT_INDEX_BITS'(pc >> shadow_pc_shift);
      store_end = addr + ADDR_W'(size) - 64'd1;
      slot      = 0;
      found     = 1'b0;
      case (op)
         OP_CLEAR: begin
            // Drop valid bits only; ages and fields stay
            for (int i = 0; i < CVT_ENTRIES; i++) begin
               if (entry_shadow[i].valid) resp.cleared_any = 1'b1;
               entry_shadow[i].valid = 1'b0;
            end
         end
         OP_CHECK: begin
            // Hit on the lowest matching entry
            for (int i = 0; i < CVT_ENTRIES; i++) begin
               if (!resp.hit && entry_shadow[i].valid &&
                   entry_shadow[i].address == addr &&
                   entry_shadow[i].load_index == lidx &&
                   entry_shadow[i].thread == thr) begin
                  resp.hit = 1'b1;
                  age_touch(i);
               end
            end
            // On a miss wipe every entry of this load and thread
            if (!resp.hit) begin
               for (int i = 0; i < CVT_ENTRIES; i++) begin
                  if (entry_shadow[i].valid && entry_shadow[i].load_index == lidx &&
                      entry_shadow[i].thread == thr) begin
                     entry_shadow[i]  = '0;
                     resp.cleared_any = 1'b1;
                  end
               end
            end
         end
         OP_STORE: begin
            // Wipe every entry whose byte range overlaps the store, sums wrap
            for (int i = 0; i < CVT_ENTRIES; i++) begin
               if (entry_shadow[i].valid) begin
                  base     = entry_shadow[i].address;
                  load_end = base + ADDR_W'(entry_shadow[i].size) - 64'd1;
                  if ((addr >= base && addr <= load_end) ||
                      (base >= addr && base <= store_end)) begin
                     entry_shadow[i]  = '0;
                     resp.cleared_any = 1'b1;
                  end
               end
            end
         end
         OP_INSERT: begin
            // Lowest free entry, else the oldest (smallest age) with lowest number on ties
            for (int i = 0; i < CVT_ENTRIES; i++) begin
               if (!found && !entry_shadow[i].valid) begin
                  slot  = i;
                  found = 1'b1;
               end
            end
            if (!found) begin
               best_age = entry_shadow[0].age;
               for (int i = 1; i < CVT_ENTRIES; i++) begin
                  if (entry_shadow[i].age < best_age) begin
                     best_age = entry_shadow[i].age;
                     slot     = i;
                  end
               end
               entry_shadow[slot].age = '0;
            end
            entry_shadow[slot].valid      = 1'b1;
            entry_shadow[slot].load_index = lidx;
            entry_shadow[slot].address    = addr;
            entry_shadow[slot].size       = size;
            entry_shadow[slot].thread     = thr;
            age_touch(slot);
         end
      endcase
      return resp;
   endfunction

   function automatic logic [ADDR_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Mix of full-range, clustered, wrapping and near-zero addresses
   function automatic logic [ADDR_W-1:0] random_address();
      case ($urandom_range(0, 3))
         0:       return random_word();
         1:       return 64'h8000 + ADDR_W'($urandom_range(0, 255));
         2:       return 64'hFFFF_FFFF_FFFF_FFFF - ADDR_W'($urandom_range(0, 15));
         default: return ADDR_W'($urandom_range(0, 15));
      endcase
   endfunction

   // Small pcs alias in the load index more often
   function automatic logic [ADDR_W-1:0] random_pc();
      if ($urandom_range(0, 1) == 0) return random_word();
      return ADDR_W'($urandom_range(0, 8191));
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      if ($urandom_range(0, 9) == 0) return SIZE_W'($urandom_range(0, 15));
      return SIZE_W'($urandom_range(1, 8));
   endfunction

   function automatic void refresh_pool(input int slot);
      pool_pc[slot]     = random_pc();
      pool_addr[slot]   = random_address();
      pool_size[slot]   = random_size();
      pool_thread[slot] = THREAD_W'($urandom_range(0, 3));
   endfunction

   // Offer one request after a random wait and record its predicted response
   task automatic send_request(
      input opcode_type          op,
      input logic [ADDR_W-1:0]   pc,
      input logic [ADDR_W-1:0]   addr,
      input logic [SIZE_W-1:0]   size,
      input logic [THREAD_W-1:0] thr
   );
      int gap;
      gap = draw_wait(SENDER);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.pc           <= pc;
      req_bus.data_address <= addr;
      req_bus.access_size  <= size;
      req_bus.thread       <= thr;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_responses.push_back(predict_response(op, pc, addr, size, thr));
      @(negedge clock);
   endtask

   // Build a request mostly from known loads so checks and stores find entries
   task automatic send_random_request();
      int                  pick;
      int                  roll;
      opcode_type          op;
      logic [ADDR_W-1:0]   pc;
      logic [ADDR_W-1:0]   addr;
      logic [SIZE_W-1:0]   size;
      logic [THREAD_W-1:0] thr;
      pick = $urandom_range(0, POOL_DEPTH - 1);
      pc   = pool_pc[pick];
      addr = pool_addr[pick];
      size = pool_size[pick];
      thr  = pool_thread[pick];
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         op   = OP_CLEAR;
         pc   = random_word();
         addr = random_word();
         size = SIZE_W'($urandom_range(0, 15));
      end else if (roll < 44) begin
         op = OP_CHECK;
         case ($urandom_range(0, 7))
            0:       addr = random_address();
            1:       thr  = THREAD_W'($urandom_range(0, 3));
            2:       pc   = random_pc();
            default: ;
         endcase
         size = SIZE_W'($urandom_range(0, 15));
      end else if (roll < 64) begin
         op = OP_STORE;
         if ($urandom_range(0, 3) == 0) addr = random_address();
         else addr = addr + ADDR_W'($urandom_range(0, 16)) - 64'd8;
         size = random_size();
         pc   = random_word();
      end else begin
         op = OP_INSERT;
         // Mostly fresh loads; some duplicates of known ones
         if ($urandom_range(0, 3) != 0) begin
            refresh_pool(pick);
            pc   = pool_pc[pick];
            addr = pool_addr[pick];
            size = pool_size[pick];
            thr  = pool_thread[pick];
         end
      end
      send_request(op, pc, addr, size, thr);
   endtask

   // Hold the request line idle until every response has come back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_responses.size() != 0) @(negedge clock);
      repeat (RESPONSE_LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_pc_shift(input logic [SHIFT_W-1:0] value);
      wait_for_drain();
      csr_bus.valid    <= 1'b1;
      csr_bus.pc_shift <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      shadow_pc_shift = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Drive the response ready: long hold first, then the per-response stall
   always @(negedge clock) begin
      if (rsp_hold_cycles != 0) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Count down the long hold
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) rsp_hold_cycles <= rsp_hold_cycles - 1;
   end

   // Check each response against the oldest owed
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding: hit %0b, cleared_any %0b",
                   rsp_bus.hit, rsp_bus.cleared_any);
            error_count++;
         end else begin
            oldest_response = pending_responses.pop_front();
            if (rsp_bus.hit !== oldest_response.hit) begin
               $error("hit: expected %0b, actual %0b", oldest_response.hit, rsp_bus.hit);
               error_count++;
            end
            if (rsp_bus.cleared_any !== oldest_response.cleared_any) begin
               $error("cleared_any: expected %0b, actual %0b",
                      oldest_response.cleared_any, rsp_bus.cleared_any);
               error_count++;
            end
         end
         rsp_stall_left = draw_wait(RECEIVER);
      end
   end

   // Check, store and clear on an empty table clear nothing
   task automatic test_empty_table();
      send_request(OP_CHECK, 64'h0, 64'h0, 4'd1, 2'd0);
      send_request(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 4'd8, 2'd3);
      send_request(OP_CLEAR, 64'h0, 64'h0, 4'd0, 2'd0);
   endtask

   // Hit, then a miss on the same load that wipes it, then a plain miss
   task automatic test_check_hit_and_miss();
      send_request(OP_INSERT, 64'h1000, 64'h2000, 4'd4, 2'd1);
      send_request(OP_CHECK,  64'h1000, 64'h2000, 4'd4, 2'd1);
      send_request(OP_CHECK,  64'h1000, 64'h2008, 4'd4, 2'd1);
      send_request(OP_CHECK,  64'h1000, 64'h2000, 4'd4, 2'd1);
   endtask

   // Overlaps at the top of the address space, zero size and largest size
   task automatic test_store_overlap();
      send_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFC, 4'd8, 2'd3);
      send_request(OP_INSERT, 64'h0, 64'h0, 4'd0, 2'd0);
      send_request(OP_INSERT, 64'h5555_5555_5555_5555, 64'h100, 4'd15, 2'd2);
      send_request(OP_STORE,  64'h0, 64'h10A, 4'd1, 2'd0);
      send_request(OP_STORE,  64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 2'd0);
      send_request(OP_STORE,  64'hAAAA_AAAA_AAAA_AAAA, 64'h0, 4'd15, 2'd1);
   endtask

   // Fill the table, force a replacement, clear all, reuse a freed entry
   task automatic test_replacement();
      for (int i = 0; i < CVT_ENTRIES + 1; i++)
         send_request(OP_INSERT, 64'h400 + ADDR_W'(i * 4), 64'h3000 + ADDR_W'(i * 8),
                      4'd8, THREAD_W'(i));
      send_request(OP_CLEAR,  64'h0, 64'h0, 4'd0, 2'd0);
      send_request(OP_INSERT, 64'h400, 64'h3000, 4'd8, 2'd0);
   endtask

   // Stall responses long enough that the block backs up its request side
   task automatic test_response_hold();
      rsp_hold_cycles <= 300;
      repeat (24) send_random_request();
   endtask

   // Pause until every response is back, then resume
   task automatic test_drain_pause();
      repeat (12) send_random_request();
      wait_for_drain();
      repeat (12) send_random_request();
   endtask

   // Random traffic across pc shift settings, extremes included
   task automatic test_random_phases();
      logic [SHIFT_W-1:0] shifts [8];
      shifts = '{3'd0, 3'd7, 3'd3, SHIFT_W'($urandom_range(0, 7)), 3'd6, 3'd1,
                 SHIFT_W'($urandom_range(0, 7)), PC_SHIFT_RESET};
      foreach (shifts[p]) begin
         write_pc_shift(shifts[p]);
         repeat (PHASE_REQUESTS) send_random_request();
      end
   endtask

   initial begin
      // Known values on every input from time zero
      req_bus.valid        = 1'b0;
      req_bus.opcode       = OP_CLEAR;
      req_bus.pc           = '0;
      req_bus.data_address = '0;
      req_bus.access_size  = '0;
      req_bus.thread       = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.pc_shift     = '0;
      shadow_pc_shift      = PC_SHIFT_RESET;
      foreach (entry_shadow[i]) entry_shadow[i] = '0;
      for (int i = 0; i < POOL_DEPTH; i++) refresh_pool(i);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_check_hit_and_miss();
      test_store_overlap();
      test_replacement();
      test_response_hold();
      test_drain_pause();
      test_random_phases();

      wait_for_drain();
      if (error_count == 0) $display("constant_verification_table_test: PASS");
      else $display("constant_verification_table_test: FAIL");
      $finish;
   end

endmodule
